[design/sfr_pkg.sv]
// Shared types and constants of the serial frame receiver with handshake supervision.
package sfr_pkg;

  typedef enum logic [1:0] {
    OP_RX_BYTE  = 2'd0,
    OP_TICK     = 2'd1,
    OP_TX_DONE  = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_NONE       = 3'd0,
    KIND_DATA       = 3'd1,
    KIND_EMPTY      = 3'd2,
    KIND_READY      = 3'd3,
    KIND_FAIL       = 3'd4,
    KIND_RX_TIMEOUT = 3'd5,
    KIND_TX_TIMEOUT = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ID   = 2'd1,
    PH_LEN  = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_START_BYTE    = 3'd0;
  localparam logic [2:0] REG_READY_ID      = 3'd1;
  localparam logic [2:0] REG_FAIL_ID       = 3'd2;
  localparam logic [2:0] REG_RX_TIMEOUT    = 3'd3;
  localparam logic [2:0] REG_TX_TIMEOUT    = 3'd4;
  localparam logic [2:0] REG_TIMEOUT_LIMIT = 3'd5;

  localparam logic [7:0]  START_BYTE_RST    = 8'hDE;
  localparam logic [7:0]  READY_ID_RST      = 8'h00;
  localparam logic [7:0]  FAIL_ID_RST       = 8'h00;
  localparam logic [15:0] RX_TIMEOUT_RST    = 16'd200;
  localparam logic [15:0] TX_TIMEOUT_RST    = 16'd1000;
  localparam logic [2:0]  TIMEOUT_LIMIT_RST = 3'd5;
  localparam logic [7:0]  HELD_ID_RST       = 8'hFF;
  localparam logic [2:0]  TALLY_MAX         = 3'd7;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  ready_id;
    logic [7:0]  fail_id;
    logic [15:0] rx_timeout_ms;
    logic [15:0] tx_timeout_ms;
    logic [2:0]  timeout_limit;
  } cfg_t;

  // Receiver and handshake state, timers excluded.
  typedef struct packed {
    phase_t     phase;
    logic [7:0] held_id;
    logic [7:0] held_length;
    logic [7:0] bytes_left;
    logic [7:0] bytes_seen;
    logic       tx_stall;
    logic [2:0] tally;
  } rx_state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] command_id;
    logic [7:0] command_length;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       last_byte;
    logic       waiting_ready;
    logic       gave_up;
  } result_t;

endpackage

[design/sfr_step.sv]
// Next-state and result logic for one received byte, tick or transmit event.
module sfr_step #(
  parameter int TIMER_BITS = 16
) (
  input  sfr_pkg::cfg_t          cfg,
  input  sfr_pkg::rx_state_t     state,
  input  logic [TIMER_BITS-1:0]  rx_elapsed,
  input  logic [TIMER_BITS-1:0]  tx_elapsed,
  input  sfr_pkg::op_t           operation,
  input  logic [7:0]             rx_byte,
  output sfr_pkg::rx_state_t     state_next,
  output logic [TIMER_BITS-1:0]  rx_elapsed_next,
  output logic [TIMER_BITS-1:0]  tx_elapsed_next,
  output sfr_pkg::result_t       result
);
  import sfr_pkg::*;

  // Timers compare against 16-bit limits; widen both sides to the larger width.
  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic [TIMER_BITS-1:0] tx_inc;
  logic [TIMER_BITS-1:0] rx_inc;
  logic                  tx_expired;
  logic                  rx_expired;

  // Saturating increments: a counter at all ones stays there.
  assign tx_inc = (&tx_elapsed) ? tx_elapsed : tx_elapsed + 1'b1;
  assign rx_inc = (&rx_elapsed) ? rx_elapsed : rx_elapsed + 1'b1;
  assign tx_expired = CMP_W'(tx_inc) > CMP_W'(cfg.tx_timeout_ms);
  assign rx_expired = CMP_W'(rx_inc) > CMP_W'(cfg.rx_timeout_ms);

  always_comb begin
    state_next      = state;
    rx_elapsed_next = rx_elapsed;
    tx_elapsed_next = tx_elapsed;
    result          = '0;
    result.kind     = KIND_NONE;

    case (operation)
      OP_RX_BYTE: begin
        case (state.phase)
          PH_IDLE: begin
            if (rx_byte == cfg.start_byte) begin
              state_next.phase = PH_ID;
              rx_elapsed_next  = '0;
            end
          end
          PH_ID: begin
            state_next.held_id = rx_byte;
            state_next.phase   = PH_LEN;
          end
          PH_LEN: begin
            state_next.held_length = rx_byte;
            if (rx_byte == 8'd0 && state.held_id == cfg.ready_id) begin
              state_next.tx_stall = 1'b0;
              state_next.tally    = '0;
              state_next.phase    = PH_IDLE;
              result.kind         = KIND_READY;
            end else if (rx_byte == 8'd0 && state.held_id == cfg.fail_id) begin
              state_next.tally = '0;
              state_next.phase = PH_IDLE;
              result.kind      = KIND_FAIL;
            end else if (rx_byte == 8'd0) begin
              state_next.tally      = '0;
              state_next.bytes_left = '0;
              state_next.bytes_seen = '0;
              state_next.phase      = PH_IDLE;
              result.kind           = KIND_EMPTY;
            end else begin
              state_next.bytes_left = rx_byte;
              state_next.bytes_seen = '0;
              state_next.phase      = PH_DATA;
            end
          end
          default: begin
            result.kind       = KIND_DATA;
            result.data_byte  = rx_byte;
            result.byte_index = state.bytes_seen;
            if (state.bytes_left <= 8'd1) begin
              result.last_byte      = 1'b1;
              state_next.bytes_left = '0;
              state_next.bytes_seen = '0;
              state_next.tally      = '0;
              state_next.phase      = PH_IDLE;
            end else begin
              state_next.bytes_left = state.bytes_left - 8'd1;
              state_next.bytes_seen = state.bytes_seen + 8'd1;
            end
          end
        endcase
      end
      OP_TICK: begin
        if (state.tx_stall) begin
          if (state.tally >= cfg.timeout_limit) begin
            state_next.tx_stall = 1'b0;
          end else begin
            tx_elapsed_next = tx_inc;
            if (tx_expired) begin
              state_next.tx_stall = 1'b0;
              if (state.tally != TALLY_MAX) begin
                state_next.tally = state.tally + 3'd1;
              end
              result.kind = KIND_TX_TIMEOUT;
            end
          end
        end
        // A receive timeout on the same tick wins the reported kind.
        if (state.phase != PH_IDLE) begin
          rx_elapsed_next = rx_inc;
          if (rx_expired) begin
            state_next.phase      = PH_IDLE;
            state_next.bytes_left = '0;
            state_next.bytes_seen = '0;
            result.kind           = KIND_RX_TIMEOUT;
          end
        end
      end
      OP_TX_DONE: begin
        state_next.tx_stall = 1'b1;
        tx_elapsed_next     = '0;
      end
      default: begin
      end
    endcase

    result.command_id     = state_next.held_id;
    result.command_length = state_next.held_length;
    result.waiting_ready  = state_next.tx_stall;
    result.gave_up        = state_next.tally >= cfg.timeout_limit;
  end

endmodule

[design/serial_frame_receiver_handshake_unit.sv]
// Top level of the serial frame receiver with ready/fail handshake and timeout supervision.
//
//  Channel   Direction  Request carries
//  s_axis    in         tuser: operation; tdata: rx_byte
//  m_axis    out        tuser: kind; tlast: last_byte; tdata: id, length, byte, index, flags
//  cfg       in         cfg_index: register number; cfg_data: value (low bits used)
//
// Each input request is first captured in an input register; once the result register is
// free or is being emptied, the step logic updates the receiver state and loads the result
// register. One request is accepted every cycle as long as the result register is free or
// is being emptied in the same cycle. A stall on m_axis holds the result and then the input
// register, after which s_axis_tready falls. Reset is synchronous and returns the
// configuration to its defaults and the receiver to waiting for a start byte.
// The configuration port is always ready; it is meant to be written while no request is open.
module serial_frame_receiver_handshake_unit #(
  parameter int TIMER_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] rx_byte
  input  logic [sfr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] command_id, [15:8] command_length, [23:16] data_byte, [31:24] byte_index,
  // [32] waiting_ready, [33] gave_up, [39:34] zero
  output logic [sfr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [2:0] kind
  output logic [2:0]                        m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [15:0]                       cfg_data
);
  import sfr_pkg::*;

  cfg_t                  cfg;
  rx_state_t             state;
  rx_state_t             state_next;
  logic [TIMER_BITS-1:0] rx_elapsed;
  logic [TIMER_BITS-1:0] rx_elapsed_next;
  logic [TIMER_BITS-1:0] tx_elapsed;
  logic [TIMER_BITS-1:0] tx_elapsed_next;

  // Input register.
  logic       in_valid;
  op_t        in_op;
  logic [7:0] in_byte;

  // Result register.
  logic       out_valid;
  result_t    out_result;
  result_t    step_result;

  logic       out_free;
  logic       advance;

  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign cfg_ready     = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte    <= START_BYTE_RST;
      cfg.ready_id      <= READY_ID_RST;
      cfg.fail_id       <= FAIL_ID_RST;
      cfg.rx_timeout_ms <= RX_TIMEOUT_RST;
      cfg.tx_timeout_ms <= TX_TIMEOUT_RST;
      cfg.timeout_limit <= TIMEOUT_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_BYTE:    cfg.start_byte    <= cfg_data[7:0];
        REG_READY_ID:      cfg.ready_id      <= cfg_data[7:0];
        REG_FAIL_ID:       cfg.fail_id       <= cfg_data[7:0];
        REG_RX_TIMEOUT:    cfg.rx_timeout_ms <= cfg_data;
        REG_TX_TIMEOUT:    cfg.tx_timeout_ms <= cfg_data;
        REG_TIMEOUT_LIMIT: cfg.timeout_limit <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: loads whenever the previous request moves on or the slot is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op   <= op_t'(s_axis_tuser);
      in_byte <= s_axis_tdata[7:0];
    end
  end

  sfr_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .cfg             (cfg),
    .state           (state),
    .rx_elapsed      (rx_elapsed),
    .tx_elapsed      (tx_elapsed),
    .operation       (in_op),
    .rx_byte         (in_byte),
    .state_next      (state_next),
    .rx_elapsed_next (rx_elapsed_next),
    .tx_elapsed_next (tx_elapsed_next),
    .result          (step_result)
  );

  // Receiver state commits only when the buffered request produces its result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PH_IDLE;
      state.held_id     <= HELD_ID_RST;
      state.held_length <= '0;
      state.bytes_left  <= '0;
      state.bytes_seen  <= '0;
      state.tx_stall    <= 1'b0;
      state.tally       <= '0;
      rx_elapsed        <= '0;
      tx_elapsed        <= '0;
    end else if (advance) begin
      state      <= state_next;
      rx_elapsed <= rx_elapsed_next;
      tx_elapsed <= tx_elapsed_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_result.kind;
  assign m_axis_tlast  = out_result.last_byte;
  assign m_axis_tdata  = {6'd0,
                          out_result.gave_up,
                          out_result.waiting_ready,
                          out_result.byte_index,
                          out_result.data_byte,
                          out_result.command_length,
                          out_result.command_id};

endmodule

[design/sfr_checker.sv]
// Port-level checks of the serial frame receiver, bound to its top level.
module sfr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sfr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [2:0]                      m_axis_tuser,
  input logic                            m_axis_tlast
);
  import sfr_pkg::*;

  // Nothing comes out in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result presented right after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Payload fields are only nonzero on data-byte results.
  a_payload_only_data: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && m_axis_tuser != KIND_DATA |->
      !m_axis_tlast && m_axis_tdata[31:16] == 16'd0)
    else $error("payload fields set on a non-data result");

  // A ready handshake always ends the transmit wait.
  a_ready_clears_wait: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && m_axis_tuser == KIND_READY |-> !m_axis_tdata[32])
    else $error("still waiting for ready after a ready handshake");

  // A transmit timeout ends the wait as well.
  a_tx_timeout_clears_wait: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && m_axis_tuser == KIND_TX_TIMEOUT |-> !m_axis_tdata[32])
    else $error("still waiting for ready after a transmit timeout");

endmodule

bind serial_frame_receiver_handshake_unit sfr_checker u_sfr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[dv/frame_rx_scoreboard_pkg.sv]
// Scoreboard class for the serial frame receiver: state tracker, expected results and checks.
`timescale 1ns / 1ps
package frame_rx_scoreboard_pkg;
  import sfr_pkg::*;

  class frame_rx_scoreboard;
    cfg_t        cfg;
    phase_t      phase;
    logic [7:0]  held_id;
    logic [7:0]  held_length;
    logic [7:0]  bytes_left;
    logic [7:0]  bytes_seen;
    logic [15:0] rx_elapsed;
    logic [15:0] tx_elapsed;
    logic        tx_stall;
    logic [2:0]  tally;
    result_t     expected_results[$];
    int          errors;

    function new();
      cfg = '{start_byte: START_BYTE_RST, ready_id: READY_ID_RST, fail_id: FAIL_ID_RST,
              rx_timeout_ms: RX_TIMEOUT_RST, tx_timeout_ms: TX_TIMEOUT_RST,
              timeout_limit: TIMEOUT_LIMIT_RST};
      phase       = PH_IDLE;
      held_id     = HELD_ID_RST;
      held_length = '0;
      bytes_left  = '0;
      bytes_seen  = '0;
      rx_elapsed  = '0;
      tx_elapsed  = '0;
      tx_stall    = 1'b0;
      tally       = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] value);
      case (idx)
        REG_START_BYTE:    cfg.start_byte    = value[7:0];
        REG_READY_ID:      cfg.ready_id      = value[7:0];
        REG_FAIL_ID:       cfg.fail_id       = value[7:0];
        REG_RX_TIMEOUT:    cfg.rx_timeout_ms = value;
        REG_TX_TIMEOUT:    cfg.tx_timeout_ms = value;
        REG_TIMEOUT_LIMIT: cfg.timeout_limit = value[2:0];
        default: ;
      endcase
    endfunction

    // Advances the tracked receiver by one request and returns the result it must produce.
    function result_t step_receiver(op_t op, logic [7:0] b);
      result_t r;
      r = '0;
      r.kind = KIND_NONE;
      case (op)
        OP_RX_BYTE: begin
          case (phase)
            PH_IDLE: begin
              if (b == cfg.start_byte) begin
                phase      = PH_ID;
                rx_elapsed = '0;
              end
            end
            PH_ID: begin
              held_id = b;
              phase   = PH_LEN;
            end
            PH_LEN: begin
              held_length = b;
              if (b == 8'd0) begin
                tally = '0;
                phase = PH_IDLE;
                // Ready wins when both handshake ids are the same.
                if (held_id == cfg.ready_id) begin
                  tx_stall = 1'b0;
                  r.kind   = KIND_READY;
                end else if (held_id == cfg.fail_id) begin
                  r.kind = KIND_FAIL;
                end else begin
                  bytes_left = '0;
                  bytes_seen = '0;
                  r.kind     = KIND_EMPTY;
                end
              end else begin
                bytes_left = b;
                bytes_seen = '0;
                phase      = PH_DATA;
              end
            end
            default: begin
              r.kind       = KIND_DATA;
              r.data_byte  = b;
              r.byte_index = bytes_seen;
              if (bytes_left <= 8'd1) begin
                r.last_byte = 1'b1;
                bytes_left  = '0;
                bytes_seen  = '0;
                tally       = '0;
                phase       = PH_IDLE;
              end else begin
                bytes_left--;
                bytes_seen++;
              end
            end
          endcase
        end
        OP_TICK: begin
          if (tx_stall) begin
            if (tally >= cfg.timeout_limit) begin
              tx_stall = 1'b0;
            end else begin
              if (tx_elapsed != '1) tx_elapsed++;
              if (tx_elapsed > cfg.tx_timeout_ms) begin
                tx_stall = 1'b0;
                if (tally != TALLY_MAX) tally++;
                r.kind = KIND_TX_TIMEOUT;
              end
            end
          end
          // The receive timeout overrides a transmit timeout on the same tick.
          if (phase != PH_IDLE) begin
            if (rx_elapsed != '1) rx_elapsed++;
            if (rx_elapsed > cfg.rx_timeout_ms) begin
              phase      = PH_IDLE;
              bytes_left = '0;
              bytes_seen = '0;
              r.kind     = KIND_RX_TIMEOUT;
            end
          end
        end
        OP_TX_DONE: begin
          tx_stall   = 1'b1;
          tx_elapsed = '0;
        end
        default: ;
      endcase
      r.command_id     = held_id;
      r.command_length = held_length;
      r.waiting_ready  = tx_stall;
      r.gave_up        = (tally >= cfg.timeout_limit);
      return r;
    endfunction

    function void note_request(op_t op, logic [7:0] b);
      expected_results.push_back(step_receiver(op, b));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void match_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [2:0] kind, logic [OUT_TDATA_W-1:0] d, logic last);
      result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, kind %0d tdata %h", $time, kind, d);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      match_field("kind", e.kind, kind);
      match_field("command_id", e.command_id, d[7:0]);
      match_field("command_length", e.command_length, d[15:8]);
      match_field("data_byte", e.data_byte, d[23:16]);
      match_field("byte_index", e.byte_index, d[31:24]);
      match_field("waiting_ready", e.waiting_ready, d[32]);
      match_field("gave_up", e.gave_up, d[33]);
      match_field("tdata padding", 0, d[OUT_TDATA_W-1:34]);
      match_field("last_byte", e.last_byte, last);
    endfunction
  endclass

endpackage

[dv/tb_top.sv]
// Top-level testbench of the serial frame receiver with ready/fail handshake supervision.
`timescale 1ns / 1ps
module tb_top;
  import sfr_pkg::*;
  import frame_rx_scoreboard_pkg::*;

  // Cycles without a handshake on any channel before the run is declared hung. The longest
  // legitimate quiet stretch is the deliberate receiver hold-off.
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 150;
  localparam int SOAK_TICKS  = 40;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 170;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = OP_UNUSED;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [2:0]             m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [2:0]             cfg_index = REG_START_BYTE;
  logic [15:0]            cfg_data = '0;

  frame_rx_scoreboard sb;

  // Configuration currently programmed, so the stimulus can build frames that match it.
  cfg_t active_cfg;
  int   items_sent  = 0;
  int   burst_left  = 0;
  int   quiet_count = 0;
  bit   gaps_on     = 1'b1;
  bit   full_speed  = 1'b0;
  bit   long_hold_req = 1'b0;

  serial_frame_receiver_handshake_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Monitor. Everything is sampled at the rising edge, before the testbench's and the
  // block's nonblocking updates land, so the order of processes does not matter. The
  // result is checked before the request of the same edge is noted: a request can never
  // produce its result in the cycle it is taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready) sb.note_request(op_t'(s_axis_tuser), s_axis_tdata);
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count == QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side. The receiver alternates ready runs with short stalls of random length,
  // sometimes with no stall at all. When the main process asks for it, it holds off for
  // a long stretch so the block fills up and pushes back on its input.
  initial begin
    int run;
    int stall;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      run   = $urandom_range(1, 30);
      stall = (full_speed || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Offers one request and returns at the edge where it is taken. Requests go out in bursts;
  // between bursts the valid line drops for a random gap unless gaps are switched off.
  task automatic send_req(op_t op, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Stops offering and waits until every expected result has been delivered. The extra
  // edge first lets the monitor note the request taken at the current edge.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes all six registers. Unused upper bits of the data bus carry random junk, which
  // the block must ignore.
  task automatic program_regs(cfg_t c);
    active_cfg = c;
    write_reg(REG_START_BYTE, {8'($urandom), c.start_byte});
    write_reg(REG_READY_ID, {8'($urandom), c.ready_id});
    write_reg(REG_FAIL_ID, {8'($urandom), c.fail_id});
    write_reg(REG_RX_TIMEOUT, c.rx_timeout_ms);
    write_reg(REG_TX_TIMEOUT, c.tx_timeout_ms);
    write_reg(REG_TIMEOUT_LIMIT, {13'($urandom), c.timeout_limit});
    cfg_valid <= 1'b0;
  endtask

  // A well-formed frame under the active start byte, with ticks sprinkled between payload
  // bytes at the given percentage.
  task automatic send_frame(logic [7:0] id, int len, int tick_pct);
    send_req(OP_RX_BYTE, active_cfg.start_byte);
    send_req(OP_RX_BYTE, id);
    send_req(OP_RX_BYTE, 8'(len));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < tick_pct) send_req(OP_TICK, 8'($urandom));
      send_req(OP_RX_BYTE, 8'($urandom));
    end
  endtask

  // Mostly well-formed frames and transmit/tick sequences, with some noise and some frames
  // that are cut short and left for the receive timer to abort.
  task automatic random_traffic(int n);
    int         stop_at;
    int         sel;
    int         len;
    logic [7:0] id;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        case ($urandom_range(0, 3))
          0:       id = active_cfg.ready_id;
          1:       id = active_cfg.fail_id;
          default: id = 8'($urandom);
        endcase
        sel = $urandom_range(0, 99);
        len = (sel < 35) ? 0 : (sel < 90) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        send_frame(id, len, 8);
      end else if (sel < 68) begin
        send_req(OP_TX_DONE, 8'($urandom));
        repeat ($urandom_range(0, 10)) send_req(OP_TICK, 8'($urandom));
      end else if (sel < 82) begin
        repeat ($urandom_range(1, 6)) send_req(OP_TICK, 8'($urandom));
      end else if (sel < 92) begin
        send_req(OP_RX_BYTE, 8'($urandom));
      end else if (sel < 95) begin
        send_req(OP_UNUSED, 8'($urandom));
      end else begin
        send_req(OP_RX_BYTE, active_cfg.start_byte);
        repeat ($urandom_range(0, 3)) send_req(OP_RX_BYTE, 8'($urandom));
        repeat ((active_cfg.rx_timeout_ms < 16) ? active_cfg.rx_timeout_ms + 2 : 4)
          send_req(OP_TICK, 8'($urandom));
      end
    end
  endtask

  initial begin
    cfg_t c;
    sb = new();
    active_cfg = sb.cfg;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset configuration: ready and fail ids are both zero, so
    // an empty frame with id zero must count as ready.
    send_req(OP_UNUSED, 8'hFF);
    send_req(OP_RX_BYTE, 8'h00);
    send_req(OP_TICK, 8'h00);
    send_req(OP_TX_DONE, 8'h55);
    send_frame(8'h00, 0, 0);
    send_frame(8'h05, 0, 0);
    send_frame(8'hFF, 1, 0);
    settle();

    // Zero timeouts: one tick fires either timer. Covers a transmit timeout alone, a
    // receive timeout alone, both on one tick, then fail and ready handshakes.
    program_regs('{start_byte: 8'h00, ready_id: 8'h11, fail_id: 8'h22, rx_timeout_ms: 16'd0,
                   tx_timeout_ms: 16'd0, timeout_limit: 3'd7});
    send_req(OP_TX_DONE, 8'h00);
    send_req(OP_TICK, 8'hFF);
    send_req(OP_RX_BYTE, 8'h00);
    send_req(OP_RX_BYTE, 8'h33);
    send_req(OP_TICK, 8'h00);
    send_req(OP_TX_DONE, 8'h00);
    send_req(OP_RX_BYTE, 8'h00);
    send_req(OP_TICK, 8'h00);
    send_frame(8'h22, 0, 0);
    send_frame(8'h11, 0, 0);
    settle();

    // Large limits: with an all-ones receive limit and a transmit limit just below it, a
    // run of ticks fires neither timer, so a partial frame left open stays aligned and the
    // transmit wait goes on. The receiver is idle here before the frame starts.
    program_regs('{start_byte: 8'hDE, ready_id: 8'h00, fail_id: 8'h01, rx_timeout_ms: 16'hFFFF,
                   tx_timeout_ms: 16'hFFFE, timeout_limit: 3'd7});
    gaps_on    = 1'b0;
    full_speed = 1'b1;
    send_req(OP_TX_DONE, 8'h00);
    send_req(OP_RX_BYTE, 8'hDE);
    send_req(OP_RX_BYTE, 8'h42);
    repeat (SOAK_TICKS) send_req(OP_TICK, 8'($urandom));
    send_req(OP_RX_BYTE, 8'h02);
    send_req(OP_RX_BYTE, 8'hAA);
    send_req(OP_RX_BYTE, 8'hBB);
    // Longest payload, so the byte index reaches its top value of 254.
    send_frame(8'h07, 255, 0);
    settle();

    // Random phases, each under its own configuration; the first two are the extremes.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: c = '{start_byte: 8'h00, ready_id: 8'h00, fail_id: 8'h00, rx_timeout_ms: 16'd0,
                 tx_timeout_ms: 16'd0, timeout_limit: 3'd0};
        1: c = '{start_byte: 8'hFF, ready_id: 8'hFF, fail_id: 8'hFF, rx_timeout_ms: 16'hFFFF,
                 tx_timeout_ms: 16'hFFFF, timeout_limit: 3'd7};
        default: begin
          c.start_byte    = ($urandom_range(0, 1) == 0) ? START_BYTE_RST : 8'($urandom);
          c.ready_id      = 8'($urandom);
          c.fail_id       = ($urandom_range(0, 3) == 0) ? c.ready_id : 8'($urandom);
          c.rx_timeout_ms = ($urandom_range(0, 4) == 0) ? RX_TIMEOUT_RST
                                                        : 16'($urandom_range(0, 10));
          c.tx_timeout_ms = 16'($urandom_range(0, 8));
          c.timeout_limit = 3'($urandom_range(0, 7));
        end
      endcase
      program_regs(c);
      gaps_on    = (p % 3 != 2);
      full_speed = (p == 5);
      if (p == 3) begin
        // Halfway through, the receiver holds off while requests keep coming.
        random_traffic(PHASE_ITEMS / 2);
        long_hold_req = 1'b1;
        random_traffic(PHASE_ITEMS / 2);
      end else begin
        random_traffic(PHASE_ITEMS);
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
design/sfr_pkg.sv
design/sfr_step.sv
design/serial_frame_receiver_handshake_unit.sv
design/sfr_checker.sv
dv/frame_rx_scoreboard_pkg.sv
dv/tb_top.sv
